// ----- design/hfc_pkg.sv -----
// ----------------------------------------------------------------------------
// hfc_pkg
// shared types and constants for the binary32 / binary16 converter
// ----------------------------------------------------------------------------
package hfc_pkg;

    localparam int unsigned OperandWidth = 32;
    localparam int unsigned PipeDepth    = 3;

    typedef enum logic
    {
        CMD_S2H = 1'b0,
        CMD_H2S = 1'b1
    } command_t;

    localparam logic [15:0] HALF_INF     = 16'h7C00;
    localparam logic [9:0]  HALF_MANT_MX = 10'h3FF;
    localparam logic [12:0] DROP_HALF    = 13'h1000;
    localparam logic [7:0]  SGL_EXP_MAX  = 8'hFF;
    localparam logic [7:0]  SUB_EXP_BASE = 8'd113;

endpackage

// ----- design/hfc_stage.sv -----
// ----------------------------------------------------------------------------
// hfc_stage
// one pipeline register stage with valid and stall
// ----------------------------------------------------------------------------
module hfc_stage #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] out_data
);
    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // stage moves when empty or when downstream takes the held item
    assign in_stall  = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= in_data;
        end
    end
endmodule

// ----- design/half_float_converter.sv -----
// ----------------------------------------------------------------------------
// half_float_converter
// binary32 <-> binary16 converter, direction per transaction
// ----------------------------------------------------------------------------
// usage:
//   input channel carries command (0: single to half, 1: half to single) and
//   operand_bits; a transaction is taken when in_valid is high and in_stall
//   is low. output channel carries result_bits under out_valid / out_stall.
//   half results sit in bits 15..0 with the upper bits zero.
// path: a transaction is registered in turn in the three register stages (decode,
//   round / normalize, pack) and shows on the output ports from the pack stage
// throughput: one transaction per cycle while out_stall is low, carried by the
//   three register stages
// reset: rst_n clears all stage valid bits; no result is pending after it
// stall: when out_stall holds, each full stage holds its item and the stall
//   walks back to in_stall; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module half_float_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits
);
    import hfc_pkg::*;

    // ---------------- stage 1: field decode and shift amount ----------------
    // payload: cmd, sign, class flags, 24-bit significand, exponent info
    typedef struct packed
    {
        logic        cmd;
        logic        sign;
        logic        special;   // inf or nan single input
        logic        zero_out;  // result is signed zero
        logic        ovf;       // result is signed infinity
        logic        sub;       // half subnormal path (single to half)
        logic [4:0]  sh;        // right shift for subnormal path 14..24
        logic [4:0]  hexp;      // biased half exponent when normal
        logic [23:0] mant;      // single significand or half mantissa
        logic [7:0]  h_exp;     // exponent field of half input, widened
    } s1_t;

    s1_t         s1_next;
    logic [7:0]  in_exp;
    logic [22:0] in_mant;
    logic [9:0]  in_hmant;
    logic [4:0]  in_hexp;
    logic signed [9:0] hexp_s;

    always_comb
    begin
        in_exp   = operand_bits[30:23];
        in_mant  = operand_bits[22:0];
        in_hexp  = operand_bits[14:10];
        in_hmant = operand_bits[9:0];
        hexp_s   = $signed({2'b00, in_exp}) - 10'sd112;
        s1_next  = '0;
        s1_next.cmd = command;
        if (command == CMD_S2H)
        begin
            s1_next.sign = operand_bits[31];
            s1_next.mant = {1'b1, in_mant};
            if (in_exp == SGL_EXP_MAX)
            begin
                s1_next.special = 1'b1;
                s1_next.mant    = {1'b0, in_mant};
            end
            else if (hexp_s >= 10'sd31)
            begin
                s1_next.ovf = 1'b1;
            end
            else if (in_exp == 8'd0 || hexp_s < -10'sd10)
            begin
                s1_next.zero_out = 1'b1;
            end
            else if (hexp_s <= 10'sd0)
            begin
                s1_next.sub = 1'b1;
                s1_next.sh  = 5'(10'sd14 - hexp_s);
            end
            else
            begin
                s1_next.hexp = hexp_s[4:0];
            end
        end
        else
        begin
            s1_next.sign  = operand_bits[15];
            s1_next.mant  = {14'd0, in_hmant};
            s1_next.h_exp = {3'd0, in_hexp};
        end
    end

    // ---------------- stage 2: rounding or normalization ----------------
    typedef struct packed
    {
        logic        cmd;
        logic        sign;
        logic        special;
        logic        zero_out;
        logic        ovf;
        logic        sub;
        logic [4:0]  hexp;
        logic [10:0] hm;        // half significand before rounding, incl. carry bit
        logic        rnd_up;
        logic [7:0]  s_exp;     // single exponent (half to single)
        logic [9:0]  s_mant;    // normalized half mantissa
        logic [22:0] nan_mant;
    } s2_t;

    logic        s1_valid, s1_stall;
    logic [$bits(s1_t)-1:0] s1_bits;
    s1_t         s1;
    s2_t         s2_next;
    logic [23:0] sub_hm, sub_rem, sub_half;
    logic [12:0] rem13;
    logic [3:0]  lz;
    logic [9:0]  norm;

    assign s1 = s1_t'(s1_bits);

    always_comb
    begin
        s2_next          = '0;
        s2_next.cmd      = s1.cmd;
        s2_next.sign     = s1.sign;
        s2_next.special  = s1.special;
        s2_next.zero_out = s1.zero_out;
        s2_next.ovf      = s1.ovf;
        s2_next.sub      = s1.sub;
        s2_next.hexp     = s1.hexp;
        s2_next.nan_mant = s1.mant[22:0];
        sub_hm   = s1.mant >> s1.sh;
        sub_rem  = s1.mant & ((24'd1 << s1.sh) - 24'd1);
        sub_half = 24'd1 << (s1.sh - 5'd1);
        rem13    = s1.mant[12:0];
        lz       = 4'd0;
        norm     = s1.mant[9:0];
        if (s1.sub)
        begin
            s2_next.hm     = sub_hm[10:0];
            s2_next.rnd_up = (sub_rem > sub_half) ||
                             (sub_rem == sub_half && sub_hm[0]);
        end
        else
        begin
            s2_next.hm     = {1'b0, s1.mant[22:13]};
            s2_next.rnd_up = (rem13 > DROP_HALF) ||
                             (rem13 == DROP_HALF && s1.mant[13]);
        end
        // half to single: normalizing shift (leading-zero count plus one) over the 10-bit mantissa
        for (int i = 9; i >= 0; i--)
        begin
            if (s1.mant[i] && lz == 4'd0 && norm == s1.mant[9:0])
            begin
                lz   = 4'(10 - i);
                norm = 10'(s1.mant[9:0] << (10 - i));
            end
        end
        s2_next.s_mant = s1.mant[9:0];
        if (s1.h_exp == 8'd0)
        begin
            // zero half input stays a signed zero
            if (s1.mant[9:0] == 10'd0)
            begin
                s2_next.s_exp  = 8'd0;
                s2_next.s_mant = 10'd0;
            end
            else
            begin
                s2_next.s_exp  = SUB_EXP_BASE - {4'd0, lz};
                s2_next.s_mant = norm;
            end
        end
        else if (s1.h_exp == 8'd31)
        begin
            s2_next.s_exp = SGL_EXP_MAX;
        end
        else
        begin
            s2_next.s_exp = s1.h_exp + 8'd112;
        end
    end

    // ---------------- stage 3: pack ----------------
    logic        s2_valid, s2_stall;
    logic [$bits(s2_t)-1:0] s2_bits;
    s2_t         s2;
    logic [31:0] res_next;
    logic [10:0] hm_r;
    logic [5:0]  e_r;
    logic [9:0]  nan_hm;

    assign s2 = s2_t'(s2_bits);

    always_comb
    begin
        hm_r     = s2.hm + {10'd0, s2.rnd_up};
        e_r      = {1'b0, s2.hexp} + {5'd0, hm_r[10]};
        nan_hm   = s2.nan_mant[22:13];
        res_next = '0;
        if (s2.cmd == CMD_S2H)
        begin
            if (s2.special)
            begin
                if (s2.nan_mant == 23'd0)
                    res_next[15:0] = {s2.sign, 15'd0} | HALF_INF;
                else
                    res_next[15:0] = {s2.sign, 15'd0} | HALF_INF |
                        {6'd0, (nan_hm == 10'd0) ? 10'd1 : nan_hm};
            end
            else if (s2.ovf || (!s2.sub && e_r >= 6'd31))
            begin
                res_next[15:0] = {s2.sign, 15'd0} | HALF_INF;
            end
            else if (s2.zero_out)
            begin
                res_next[15:0] = {s2.sign, 15'd0};
            end
            else if (s2.sub)
            begin
                res_next[15:0] = {s2.sign, 4'd0, hm_r};
            end
            else
            begin
                res_next[15:0] = {s2.sign, e_r[4:0], hm_r[9:0] & HALF_MANT_MX};
            end
        end
        else
        begin
            res_next = {s2.sign, s2.s_exp, s2.s_mant, 13'd0};
        end
    end

    hfc_stage #(.WIDTH($bits(s1_t))) u_s1 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(s1_next),
        .out_valid(s1_valid), .out_stall(s1_stall), .out_data(s1_bits)
    );

    hfc_stage #(.WIDTH($bits(s2_t))) u_s2 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s1_valid), .in_stall(s1_stall), .in_data(s2_next),
        .out_valid(s2_valid), .out_stall(s2_stall), .out_data(s2_bits)
    );

    hfc_stage #(.WIDTH(OperandWidth)) u_s3 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s2_valid), .in_stall(s2_stall), .in_data(res_next),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(result_bits)
    );
endmodule
